// ===== sv/pcct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcct_pkg: shared types and constants for the crosstalk correction core
// Pixel and result payload structs, fixed-point widths, register indexes.
// ----------------------------------------------------------------------------
package pcct_pkg;

  // Input and output field widths
  localparam int PixW   = 8;
  localparam int DiffW  = PixW + 1;       // cam - dark, signed

  // Normalized channel value a = d/255 in signed Q1.16, and b = 1 - a
  localparam int FracA  = 16;
  localparam int QuotW  = 2 * PixW + 1;   // |a| up to 65536
  localparam int AW     = QuotW + 1;      // signed a
  localparam int BW     = AW + 1;         // b in 0..131072, signed
  localparam logic signed [BW-1:0] QOne = BW'(65536);
  localparam int RndQ16 = 32768;          // half LSB of Q.16 from Q.32
  localparam int RndQ15 = 16384;          // same for 2ab, taken from ab

  // Basis terms and coefficients
  localparam int TermW      = 20;
  localparam int CoefW      = 20;
  localparam int CoefPerGrp = 3;
  localparam int NumCoef    = 9;
  localparam int NumGrp     = NumCoef / CoefPerGrp;
  localparam int GrpW       = CoefW * CoefPerGrp;

  // Product and accumulator widths, corrected value in Q.41
  localparam int XpW     = 2 * TermW;
  localparam int CpW     = XpW + CoefW;
  localparam int SumW    = 64;
  localparam int FracOut = 41;
  localparam int HiW     = SumW - FracOut;

  // Output level mapping
  localparam int LevelBias = 128;
  localparam int LevelMax  = 255;

  // Threshold register
  localparam int ThrW = 9;
  localparam logic signed [ThrW-1:0] ThrReset = ThrW'(-20);

  // Configuration port
  localparam int DataW = 64;
  localparam int AddrW = 5;
  localparam int IdxW  = 2;
  localparam logic [IdxW-1:0] REG_COEF_LOW  = 2'd0;
  localparam logic [IdxW-1:0] REG_COEF_MID  = 2'd1;
  localparam logic [IdxW-1:0] REG_COEF_HIGH = 2'd2;
  localparam logic [IdxW-1:0] REG_MASK_THR  = 2'd3;

  typedef logic signed [TermW-1:0] term_t;

  typedef struct packed {
    term_t sq_a;    // a^2
    term_t sq_b;    // (1-a)^2
    term_t mix;     // 2a(1-a)
  } basis_t;

  typedef struct packed {
    logic [PixW-1:0] cam_blue;
    logic [PixW-1:0] cam_green;
    logic [PixW-1:0] cam_red;
    logic [PixW-1:0] dark_blue;
    logic [PixW-1:0] dark_green;
    logic [PixW-1:0] dark_red;
  } pixel_t;

  typedef struct packed {
    logic [PixW-1:0] corrected_level;
    logic            below_mask;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/pcct_basis.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcct_basis: quadratic basis terms of one color channel
// Three register stages: normalize, square, round to Q.16.
// ----------------------------------------------------------------------------
module pcct_basis import pcct_pkg::*; (
  input  logic            clk,
  input  logic [PixW-1:0] cam,
  input  logic [PixW-1:0] dark,
  output basis_t          terms
);

  logic signed [DiffW-1:0]   diff;
  logic [PixW-1:0]           mag;
  logic [QuotW-1:0]          quot;
  logic signed [AW-1:0]      a_val;
  logic signed [BW-1:0]      b_val;
  logic signed [AW-1:0]      a_q;
  logic signed [BW-1:0]      b_q;
  logic signed [2*AW-1:0]    aa_prod;
  logic signed [2*BW-1:0]    bb_prod;
  logic signed [AW+BW-1:0]   ab_prod;
  logic signed [2*AW-1:0]    aa_rnd;
  logic signed [2*BW-1:0]    bb_rnd;
  logic signed [AW+BW-1:0]   ab_rnd;

  // m*65536/255 rounded equals m*257 plus one when m is at least 128
  always_comb begin
    diff  = $signed({1'b0, cam}) - $signed({1'b0, dark});
    mag   = diff[DiffW-1] ? PixW'(-diff) : diff[PixW-1:0];
    quot  = QuotW'({mag, mag}) + QuotW'(mag[PixW-1]);
    a_val = diff[DiffW-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    b_val = QOne - BW'(a_val);
  end

  // round half up: add half an LSB, floor by arithmetic slice
  always_comb begin
    aa_rnd = aa_prod + (2*AW)'(RndQ16);
    bb_rnd = bb_prod + (2*BW)'(RndQ16);
    ab_rnd = ab_prod + (AW+BW)'(RndQ15);
  end

  always_ff @(posedge clk) begin
    a_q         <= a_val;
    b_q         <= b_val;
    aa_prod     <= a_q * a_q;
    bb_prod     <= b_q * b_q;
    ab_prod     <= a_q * b_q;
    terms.sq_a  <= aa_rnd[FracA+TermW-1:FracA];
    terms.sq_b  <= bb_rnd[FracA+TermW-1:FracA];
    terms.mix   <= ab_rnd[FracA+TermW-2:FracA-1];
  end

endmodule
`default_nettype wire

// ===== sv/pixel_crosstalk_correct_threshold_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_crosstalk_correct_threshold_core: dark-frame and crosstalk correction
// Subtracts the dark frame, removes a quadratic blue/red crosstalk model from
// the green channel and thresholds the corrected value into a mask bit.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload           Notes
//  -------   -------------------------  ----------------  ---------------------
//  input     start / busy               pixel  (pixel_t)  taken when start & !busy
//  result    done (one-cycle strobe)    result (result_t) no back-pressure
//  config    APB psel/penable/pwrite    paddr/pwdata      8-byte register stride
//
//  One pixel transaction enters every cycle; results leave in the order taken.
//  The depth is set by the basis stages (normalize, square, round), the cross
//  products, the coefficient weights, the adder tree (partial sums, then the
//  total), the green subtraction and the output, each behind its own register.
//  busy is high only during reset; there is no stall anywhere in the pipe.
//  Reset clears the valid bits and loads the register defaults (coefficients
//  zero, threshold -20); payload registers are not reset.
//
module pixel_crosstalk_correct_threshold_core import pcct_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // pixel transaction
  input  logic             start,
  output logic             busy,
  input  pixel_t           pixel,
  // result transaction
  output logic             done,
  output result_t          result,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int Stages = 9;
  localparam int DgLen  = 7;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [GrpW-1:0]        coef_grp [NumGrp];
  logic signed [ThrW-1:0] thr;
  logic                   cfg_wr;
  logic [IdxW-1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[AddrW-1:AddrW-IdxW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NumGrp; g++) begin
        coef_grp[g] <= '0;
      end
      thr <= ThrReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_COEF_LOW:  coef_grp[0] <= pwdata[GrpW-1:0];
        REG_COEF_MID:  coef_grp[1] <= pwdata[GrpW-1:0];
        REG_COEF_HIGH: coef_grp[2] <= pwdata[GrpW-1:0];
        REG_MASK_THR:  thr         <= pwdata[ThrW-1:0];
        default:       ;
      endcase
    end
  end

  // Read back: coefficient groups zero-extended, threshold sign-extended
  always_comb begin
    unique case (cfg_idx)
      REG_COEF_LOW:  prdata = DataW'(coef_grp[0]);
      REG_COEF_MID:  prdata = DataW'(coef_grp[1]);
      REG_COEF_HIGH: prdata = DataW'(coef_grp[2]);
      REG_MASK_THR:  prdata = DataW'(thr);
      default:       prdata = '0;
    endcase
  end

  // Slice the nine signed Q10.9 coefficients, lowest field first
  logic signed [CoefW-1:0] coef [NumCoef];
  for (genvar k = 0; k < NumCoef; k++) begin : g_coef
    assign coef[k] = coef_grp[k / CoefPerGrp][(k % CoefPerGrp)*CoefW +: CoefW];
  end

  // --------------------------------------------------------------------------
  // Valid line: one bit per stage, advance every cycle
  // --------------------------------------------------------------------------
  logic              accept;
  logic [Stages-1:0] vld;

  assign busy   = rst;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Stages-2:0], accept};
    end
  end

  assign done = vld[Stages-1];

  // --------------------------------------------------------------------------
  // Stages 1-3: basis terms of blue and red, green difference alongside
  // --------------------------------------------------------------------------
  basis_t terms_b;
  basis_t terms_r;

  pcct_basis u_basis_blue (
    .clk   (clk),
    .cam   (pixel.cam_blue),
    .dark  (pixel.dark_blue),
    .terms (terms_b)
  );

  pcct_basis u_basis_red (
    .clk   (clk),
    .cam   (pixel.cam_red),
    .dark  (pixel.dark_red),
    .terms (terms_r)
  );

  // Hold dg in a delay line until the accumulated sum catches up
  logic signed [DiffW-1:0] dg_pipe [DgLen];

  always_ff @(posedge clk) begin
    dg_pipe[0] <= $signed({1'b0, pixel.cam_green}) - $signed({1'b0, pixel.dark_green});
    for (int s = 1; s < DgLen; s++) begin
      dg_pipe[s] <= dg_pipe[s-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: cross products, blue term i times red term j at index i + 3j
  // Stage 5: weight each by its coefficient
  // --------------------------------------------------------------------------
  term_t                 tb [CoefPerGrp];
  term_t                 tr [CoefPerGrp];
  logic signed [XpW-1:0] xp [NumCoef];
  logic signed [CpW-1:0] cp [NumCoef];

  always_comb begin
    tb[0] = terms_b.sq_a;
    tb[1] = terms_b.sq_b;
    tb[2] = terms_b.mix;
    tr[0] = terms_r.sq_a;
    tr[1] = terms_r.sq_b;
    tr[2] = terms_r.mix;
  end

  for (genvar j = 0; j < CoefPerGrp; j++) begin : g_row
    for (genvar i = 0; i < CoefPerGrp; i++) begin : g_col
      always_ff @(posedge clk) begin
        xp[i + CoefPerGrp*j] <= tb[i] * tr[j];
        cp[i + CoefPerGrp*j] <= xp[i + CoefPerGrp*j] * coef[i + CoefPerGrp*j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 6-7: adder tree, three partial sums then the total
  // Stage 8: corrected green in Q.41
  // --------------------------------------------------------------------------
  logic signed [SumW-1:0] psum [NumGrp];
  logic signed [SumW-1:0] total;
  logic signed [SumW-1:0] gr;
  logic signed [SumW-1:0] dg_q41;

  for (genvar g = 0; g < NumGrp; g++) begin : g_psum
    always_ff @(posedge clk) begin
      psum[g] <= SumW'(cp[CoefPerGrp*g]) + SumW'(cp[CoefPerGrp*g + 1])
               + SumW'(cp[CoefPerGrp*g + 2]);
    end
  end

  assign dg_q41 = $signed({{(SumW-DiffW-FracOut){dg_pipe[DgLen-1][DiffW-1]}},
                           dg_pipe[DgLen-1], {FracOut{1'b0}}});

  always_ff @(posedge clk) begin
    total <= psum[0] + psum[1] + psum[2];
    gr    <= dg_q41 - total;
  end

  // --------------------------------------------------------------------------
  // Stage 9: level and mask. Both only need floor(gr / 2^41): the threshold
  // is an integer, and truncating gr + 128 is the floor once it is positive.
  // --------------------------------------------------------------------------
  logic signed [HiW-1:0] gr_hi;
  logic signed [HiW:0]   lvl_wide;
  logic [PixW-1:0]       lvl_next;

  always_comb begin
    gr_hi    = gr[SumW-1:FracOut];
    lvl_wide = (HiW+1)'(gr_hi) + (HiW+1)'(LevelBias);
    if (lvl_wide < 0) begin
      lvl_next = '0;
    end else if (lvl_wide > (HiW+1)'(LevelMax)) begin
      lvl_next = PixW'(LevelMax);
    end else begin
      lvl_next = lvl_wide[PixW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    result.corrected_level <= lvl_next;
    result.below_mask      <= (gr_hi < HiW'(thr));
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Every result traces back to an earlier taken pixel
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, Stages))
    else $error("result strobe without a matching pixel transaction");

  // Every pixel taken yields its result
  a_accept_gives_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##9 done)
    else $error("pixel transaction lost in the pipeline");

  // A masked pixel cannot report a nonzero level at or above threshold + 128
  a_mask_vs_level: assert property (@(posedge clk) disable iff (rst)
    (done && result.below_mask) |->
      ($signed({2'b00, result.corrected_level}) <= 10'(thr) + 10'(LevelBias - 1)
       || result.corrected_level == '0))
    else $error("mask bit disagrees with corrected level");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for pixel_crosstalk_correct_threshold_core
// Feeds pixel transactions through start/busy and writes the APB registers
// between phases. An in-bench fixed-point model computes each corrected level
// and mask bit. The model follows the block's integer arithmetic exactly. The
// bench checks every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import pcct_pkg::*;

  localparam int ClkHalf    = 5;
  localparam int ResetLen   = 10;
  localparam int StallLimit = 1000;   // cycles with no transaction at all
  localparam int TailCycles = 20;     // pipe depth is nine; allow margin
  localparam int RandPhases = 10;
  localparam int PhaseItems = 188;
  localparam int IdlePct    = 38;
  localparam int ReportCap  = 40;

  // Coefficient field patterns used when building a register setting
  typedef enum int {
    CF_ANY,        // any 20-bit pattern
    CF_MODERATE,   // small signed values, keeps levels off the rails
    CF_MAX_POS,    // most positive Q10.9
    CF_MAX_NEG,    // most negative Q10.9
    CF_MIXED       // a randomly chosen pattern per field
  } coef_mode_e;

  logic             clk     = 1'b0;
  logic             rst     = 1'b1;
  logic             start   = 1'b0;
  logic             busy;
  pixel_t           pixel   = '0;
  logic             done;
  result_t          result;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Register image used by the correction model; only touched while idle
  logic [GrpW-1:0]        coef_grp [NumGrp] = '{default: '0};
  logic signed [ThrW-1:0] thr_reg           = ThrReset;

  pixel_t  pixel_q[$];       // pixels waiting to be offered
  result_t corrected_q[$];   // predicted results, oldest first
  int      mismatches  = 0;
  int      idle_cycles = 0;
  bit      steady      = 1'b0;   // suppress start gaps for one phase

  pixel_crosstalk_correct_threshold_core dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .pixel   (pixel),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #ClkHalf clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Correction model
  // ---------------------------------------------------------------------------

  // Three quadratic terms of one channel difference, a = d/255 in Q1.16.
  // Each term is exact in Q.32 and rounded half up back to Q.16.
  function automatic basis_t channel_basis(input longint d);
    longint mag, a, b;
    basis_t t;
    mag = (d < 0) ? -d : d;
    a   = (mag * 65536 + 127) / 255;
    if (d < 0) a = -a;
    b   = 65536 - a;
    // >>> on a signed longint is a floor divide, matching round half up
    t.sq_a  = term_t'((a * a + RndQ16) >>> FracA);
    t.sq_b  = term_t'((b * b + RndQ16) >>> FracA);
    t.mix   = term_t'((2 * a * b + RndQ16) >>> FracA);
    return t;
  endfunction

  function automatic result_t correct_pixel(input pixel_t p);
    longint db, dg, dr, acc, gr, biased, thr_q, lvl;
    longint bt[3], rt[3];
    basis_t bb, rb;
    logic signed [CoefW-1:0] c;
    result_t r;
    db  = longint'(p.cam_blue)  - longint'(p.dark_blue);
    dg  = longint'(p.cam_green) - longint'(p.dark_green);
    dr  = longint'(p.cam_red)   - longint'(p.dark_red);
    bb  = channel_basis(db);
    rb  = channel_basis(dr);
    bt  = '{bb.sq_a, bb.sq_b, bb.mix};
    rt  = '{rb.sq_a, rb.sq_b, rb.mix};
    acc = 0;
    // Blue term i and red term j weight coefficient i + 3j, i.e. field i of group j
    for (int j = 0; j < NumGrp; j++) begin
      for (int i = 0; i < CoefPerGrp; i++) begin
        c   = coef_grp[j][i*CoefW +: CoefW];
        acc += bt[i] * rt[j] * longint'(c);
      end
    end
    gr     = dg * (longint'(1) << FracOut) - acc;
    biased = gr + LevelBias * (longint'(1) << FracOut);
    if (biased < 0) begin
      lvl = 0;
    end else begin
      lvl = biased >>> FracOut;
      if (lvl > LevelMax) lvl = LevelMax;
    end
    thr_q = longint'(thr_reg) * (longint'(1) << FracOut);
    r.corrected_level = lvl[PixW-1:0];
    r.below_mask      = (gr < thr_q);
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= ReportCap) $display("[%0t] MISMATCH %s", $time, what);
  endtask

  // Append one pixel to the tail of the pending queue
  function automatic void queue_pixel(input pixel_t p);
    pixel_q.insert(pixel_q.size(), p);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer queued pixels on start, hold while busy, gap at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pixel_driver
    bit gap;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      // Either nothing was offered or the offer was just taken: pick the next
      gap = !steady && ($urandom_range(99, 0) < IdlePct);
      if (pixel_q.size() != 0 && !gap) begin
        start <= 1'b1;
        pixel <= pixel_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every taken pixel, check every done strobe
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst) begin
      if (done) begin
        if (corrected_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result level=%0d mask=%0b",
                                  result.corrected_level, result.below_mask));
        end else begin
          want = corrected_q.pop_front();
          if (result.corrected_level !== want.corrected_level)
            flag_mismatch($sformatf("corrected_level got %0d want %0d",
                                    result.corrected_level, want.corrected_level));
          if (result.below_mask !== want.below_mask)
            flag_mismatch($sformatf("below_mask got %0b want %0b",
                                    result.below_mask, want.below_mask));
        end
      end
      if (start && !busy) corrected_q.insert(corrected_q.size(), correct_pixel(pixel));
    end
  end

  // Watchdog: any pixel, result or register write counts as progress
  always @(posedge clk) begin : stall_watch
    if (rst || (start && !busy) || done || (psel && penable && pwrite)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One APB write: setup, access, then drop the select. The register takes
  // the value on the access edge, so update the model image there too.
  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 3'b000});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_COEF_LOW, REG_COEF_MID, REG_COEF_HIGH: coef_grp[idx] = val[GrpW-1:0];
      REG_MASK_THR:                              thr_reg       = val[ThrW-1:0];
      default: ;
    endcase
  endtask

  // Hold until every offered pixel has been taken and answered
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_q.size() != 0 || start || corrected_q.size() != 0);
  endtask

  function automatic pixel_t mk_pixel(input int cb, input int cg, input int cr,
                                      input int kb, input int kg, input int kr);
    pixel_t p;
    p = '{PixW'(cb), PixW'(cg), PixW'(cr), PixW'(kb), PixW'(kg), PixW'(kr)};
    return p;
  endfunction

  // Lean on the rails: a fifth of the bytes are 0 or 255
  function automatic logic [PixW-1:0] pick_byte();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PixW'($urandom_range(255, 0));
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.cam_blue   = pick_byte();
    p.cam_green  = pick_byte();
    p.cam_red    = pick_byte();
    p.dark_blue  = pick_byte();
    p.dark_green = pick_byte();
    p.dark_red   = pick_byte();
    // Zero differences now and then: a = 0 is its own corner of the basis
    if ($urandom_range(9, 0) == 0) p.dark_blue  = p.cam_blue;
    if ($urandom_range(9, 0) == 0) p.dark_green = p.cam_green;
    if ($urandom_range(9, 0) == 0) p.dark_red   = p.cam_red;
    return p;
  endfunction

  function automatic logic [CoefW-1:0] coef_field(input coef_mode_e mode);
    int k;
    case (mode)
      CF_MAX_POS: return {1'b0, {(CoefW-1){1'b1}}};
      CF_MAX_NEG: return {1'b1, {(CoefW-1){1'b0}}};
      CF_MODERATE: begin
        k = $urandom_range(12, 4);
        return CoefW'(int'($urandom_range((1 << k) - 1, 0)) - (1 << (k - 1)));
      end
      default: return CoefW'($urandom);
    endcase
  endfunction

  // Write all three groups; random bits above the 60-bit field must be dropped
  task automatic write_coefs(input coef_mode_e mode);
    logic [DataW-1:0] val;
    coef_mode_e fm;
    for (int g = 0; g < NumGrp; g++) begin
      val = {$urandom, $urandom};
      for (int f = 0; f < CoefPerGrp; f++) begin
        fm = (mode == CF_MIXED) ? coef_mode_e'($urandom_range(CF_MAX_NEG, CF_ANY)) : mode;
        val[f*CoefW +: CoefW] = coef_field(fm);
      end
      write_reg(IdxW'(g), val);
    end
  endtask

  task automatic write_threshold(input logic [ThrW-1:0] thr);
    logic [DataW-1:0] val;
    val           = {$urandom, $urandom};
    val[ThrW-1:0] = thr;
    write_reg(REG_MASK_THR, val);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : test_seq
    coef_mode_e mode;
    logic [ThrW-1:0] thr;
    repeat (ResetLen) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: zero coefficients, threshold -20. Level is dg + 128, so
    // walk the saturation edges and both sides of the threshold.
    queue_pixel(mk_pixel(  0,   0,   0,   0,   0,   0));
    queue_pixel(mk_pixel(255, 255, 255,   0,   0,   0));
    queue_pixel(mk_pixel(  0,   0,   0, 255, 255, 255));
    queue_pixel(mk_pixel(  0,   0,   0,   0,  20,   0));
    queue_pixel(mk_pixel(  0,   0,   0,   0,  21,   0));
    queue_pixel(mk_pixel(  0, 127,   0,   0,   0,   0));
    queue_pixel(mk_pixel(  0, 128,   0,   0,   0,   0));
    queue_pixel(mk_pixel(  0,   0,   0,   0, 128,   0));
    queue_pixel(mk_pixel(  0,   0,   0,   0, 129,   0));
    wait_drained();

    // Hand-picked coefficients with garbage in the unused upper bits and a
    // zero threshold. With all differences zero only coefficient 4 (0.5)
    // survives, so the level truncates 127.5 and the mask sits just below.
    write_reg(REG_COEF_LOW,  {4'hA, 20'sd1, -20'sd512, 20'sd513});
    write_reg(REG_COEF_MID,  {4'hA, 20'h7FFFF, 20'sd256, -20'sd1});
    write_reg(REG_COEF_HIGH, {4'hA, -20'sd3, 20'sd3, 20'h80000});
    write_reg(REG_MASK_THR,  64'hFFFF_FFFF_FFFF_FE00);
    @(negedge clk);
    queue_pixel(mk_pixel(255, 128,   0,   0, 128, 255));
    queue_pixel(mk_pixel(  0, 128, 255, 255, 128,   0));
    queue_pixel(mk_pixel(128, 100, 128,   0, 100,   0));
    queue_pixel(mk_pixel(  0, 100,   0,   1,  90,   1));
    queue_pixel(mk_pixel(  1,  90,   1,   0, 100,   0));
    queue_pixel(mk_pixel(200,  50,  60, 200,  50,  60));
    queue_pixel(mk_pixel( 17,   0, 240, 240, 255,  17));
    queue_pixel(mk_pixel(255, 255, 255,   0,   0,   0));
    queue_pixel(mk_pixel(  0,   0,   0, 255, 255, 255));
    queue_pixel(mk_pixel( 90, 200,  30,  10,  70, 220));
    wait_drained();

    // Random phases: the first two pin every coefficient at its extreme and the
    // threshold at +255 or -255, the rest mostly use moderate weights so that levels land
    // inside 0..255 instead of always clipping.
    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0: begin mode = CF_MAX_POS; thr = ThrW'(255);  end
        1: begin mode = CF_MAX_NEG; thr = ThrW'(-255); end
        2: begin mode = CF_ANY;     thr = ThrW'($urandom); end
        3: begin mode = CF_MIXED;   thr = ThrW'($urandom); end
        default: begin
          mode = CF_MODERATE;
          thr  = ThrW'(int'($urandom_range(60, 0)) - 30);
        end
      endcase
      write_coefs(mode);
      write_threshold(thr);
      @(negedge clk);
      steady = (ph == 5);
      for (int n = 0; n < PhaseItems; n++) queue_pixel(rand_pixel());
      wait_drained();
    end
    steady = 1'b0;

    // Let any stray strobe show up before deciding
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
